### src/lens_undistort_point_macros.svh
// Assertion macros for the lens undistortion block.
`ifndef LENS_UNDISTORT_POINT_MACROS_SVH
`define LENS_UNDISTORT_POINT_MACROS_SVH
`ifndef SYNTHESIS
`define LUP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lens_undistort_point check failed");
`define LUP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lens_undistort_point reset check failed");
`else
`define LUP_ASSERT(lbl, prop)
`define LUP_ASSERT_RST(lbl, prop)
`endif
`endif

### src/lup_pkg.sv
// Shared types, constants and fixed-point helpers for the lens undistortion block.
package lup_pkg;

  localparam int FRAC   = 28;
  localparam int DIV_W  = 40;
  localparam int FOC_W  = 16;
  localparam int PIX_W  = 12;
  localparam int COEF_W = 31;

  localparam logic [FOC_W-1:0]  FOCAL_RST  = 16'd560;
  localparam logic [PIX_W-1:0]  CENTER_RST = 12'd1368;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_P1       = 3'd6,
    REG_P2       = 3'd7
  } reg_idx_t;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t xd;
    q_t yd;
  } pt_t;

  typedef struct packed {
    q_t k1;
    q_t k2;
    q_t p1;
    q_t p2;
  } coef_t;

  typedef struct packed {
    logic [FOC_W-1:0] rem;
    logic [DIV_W-1:0] n;
    logic [DIV_W-1:0] q;
    logic             neg;
  } div_t;

  function automatic q_t qadd(q_t a, q_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  function automatic q_t qsub(q_t a, q_t b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  function automatic q_t qmul(q_t a, q_t b);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = 64'(a) * 64'(b);
    r = (p + 64'sd134217728) >>> FRAC;
    if (r > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (r < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return r[31:0];
  endfunction

  function automatic div_t div_step(div_t d, logic [FOC_W-1:0] f);
    div_t             o;
    logic [FOC_W:0]   t;
    logic [FOC_W:0]   dif;
    t   = {d.rem, d.n[DIV_W-1]};
    dif = t - {1'b0, f};
    o.neg = d.neg;
    o.n   = {d.n[DIV_W-2:0], 1'b0};
    if (t >= {1'b0, f}) begin
      o.rem = dif[FOC_W-1:0];
      o.q   = {d.q[DIV_W-2:0], 1'b1};
    end else begin
      o.rem = t[FOC_W-1:0];
      o.q   = {d.q[DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic q_t div_final(div_t d);
    if (!d.neg) begin
      if (d.q > 40'h00_7FFF_FFFF) begin
        return 32'sh7FFF_FFFF;
      end
      return d.q[31:0];
    end
    if (d.q > 40'h00_8000_0000) begin
      return 32'sh8000_0000;
    end
    return -d.q[31:0];
  endfunction

endpackage

### src/lup_distort_step.sv
// One distortion-removal pass: evaluates d(estimate) and forms xd - d over six stages.
module lup_distort_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  lup_pkg::pt_t  in_pt,
  input  lup_pkg::coef_t coef,
  output logic          out_valid,
  output lup_pkg::pt_t  out_pt
);
  import lup_pkg::*;

  logic [5:0] v_r;

  pt_t a_pt_r, b_pt_r, c_pt_r, d_pt_r, e_pt_r, f_pt_r;
  q_t  a_x2_r, a_y2_r, a_xy_r;
  q_t  b_r2_r, b_x2d_r, b_y2d_r, b_xy_r;
  q_t  c_r4_r, c_k1r2_r, c_tinx_r, c_tiny_r, c_cx_r, c_cy_r;
  q_t  d_rad_r, d_tx_r, d_ty_r, d_cx2_r, d_cy2_r;
  q_t  e_s1x_r, e_s1y_r, e_tx_r, e_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pt_r   <= in_pt;
      a_x2_r   <= qmul(in_pt.x, in_pt.x);
      a_y2_r   <= qmul(in_pt.y, in_pt.y);
      a_xy_r   <= qmul(in_pt.x, in_pt.y);

      b_pt_r   <= a_pt_r;
      b_r2_r   <= qadd(a_x2_r, a_y2_r);
      b_x2d_r  <= qadd(a_x2_r, a_x2_r);
      b_y2d_r  <= qadd(a_y2_r, a_y2_r);
      b_xy_r   <= a_xy_r;

      c_pt_r   <= b_pt_r;
      c_r4_r   <= qmul(b_r2_r, b_r2_r);
      c_k1r2_r <= qmul(coef.k1, b_r2_r);
      c_tinx_r <= qadd(b_r2_r, b_x2d_r);
      c_tiny_r <= qadd(b_r2_r, b_y2d_r);
      c_cx_r   <= qmul(coef.p1, b_xy_r);
      c_cy_r   <= qmul(coef.p2, b_xy_r);

      d_pt_r   <= c_pt_r;
      d_rad_r  <= qadd(c_k1r2_r, qmul(coef.k2, c_r4_r));
      d_tx_r   <= qmul(coef.p2, c_tinx_r);
      d_ty_r   <= qmul(coef.p1, c_tiny_r);
      d_cx2_r  <= qadd(c_cx_r, c_cx_r);
      d_cy2_r  <= qadd(c_cy_r, c_cy_r);

      e_pt_r   <= d_pt_r;
      e_s1x_r  <= qadd(qmul(d_pt_r.x, d_rad_r), d_cx2_r);
      e_s1y_r  <= qadd(qmul(d_pt_r.y, d_rad_r), d_cy2_r);
      e_tx_r   <= d_tx_r;
      e_ty_r   <= d_ty_r;

      f_pt_r.x  <= qsub(e_pt_r.xd, qadd(e_s1x_r, e_tx_r));
      f_pt_r.y  <= qsub(e_pt_r.yd, qadd(e_s1y_r, e_ty_r));
      f_pt_r.xd <= e_pt_r.xd;
      f_pt_r.yd <= e_pt_r.yd;
    end
  end

  assign out_valid = v_r[5];
  assign out_pt    = f_pt_r;

endmodule

### src/lens_undistort_point.sv
// Top level of the lens undistortion block: config registers, normalizing divider, passes.
//
// Usage:
//   in_*  : one request per distorted pixel, tdata = {pixel_row, pixel_col}.
//   out_* : one result per request, in order, tdata = {norm_y, norm_x}, Q4.28.
//   cfg_* : APB registers at 4*i: focal_x, focal_y, center_x, center_y,
//           k1, k2, p1, p2. Write only while no request is in flight.
// Pipeline: the accepting edge loads the divider input stage, then come a
//   40-stage restoring divider for the normalization, one rounding stage
//   and ITERATIONS+1 six-stage distortion passes.
// Throughput: one request per cycle while out_tready is high.
// Reset: rst_n (synchronous) empties the pipeline and loads the default
//   intrinsics with zero distortion coefficients.
// Stall: while a result waits with out_tready low, the whole pipeline holds
//   and in_tready drops; nothing is lost or repeated.
module lens_undistort_point #(
  parameter int ITERATIONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // pixel_col[11:0], pixel_row[23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // norm_x[31:0], norm_y[63:32]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lup_pkg::*;

  localparam int NPASS = ITERATIONS + 1;

  logic [FOC_W-1:0]  focal_x_r, focal_y_r;
  logic [PIX_W-1:0]  center_x_r, center_y_r;
  logic [COEF_W-1:0] k1_r, k2_r, p1_r, p2_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= FOCAL_RST;
      focal_y_r  <= FOCAL_RST;
      center_x_r <= CENTER_RST;
      center_y_r <= CENTER_RST;
      k1_r       <= '0;
      k2_r       <= '0;
      p1_r       <= '0;
      p2_r       <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FOCAL_X:  focal_x_r  <= cfg_pwdata[FOC_W-1:0];
        REG_FOCAL_Y:  focal_y_r  <= cfg_pwdata[FOC_W-1:0];
        REG_CENTER_X: center_x_r <= cfg_pwdata[PIX_W-1:0];
        REG_CENTER_Y: center_y_r <= cfg_pwdata[PIX_W-1:0];
        REG_K1:       k1_r       <= cfg_pwdata[COEF_W-1:0];
        REG_K2:       k2_r       <= cfg_pwdata[COEF_W-1:0];
        REG_P1:       p1_r       <= cfg_pwdata[COEF_W-1:0];
        REG_P2:       p2_r       <= cfg_pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FOCAL_X:  cfg_prdata = {16'd0, focal_x_r};
      REG_FOCAL_Y:  cfg_prdata = {16'd0, focal_y_r};
      REG_CENTER_X: cfg_prdata = {20'd0, center_x_r};
      REG_CENTER_Y: cfg_prdata = {20'd0, center_y_r};
      REG_K1:       cfg_prdata = {1'b0, k1_r};
      REG_K2:       cfg_prdata = {1'b0, k2_r};
      REG_P1:       cfg_prdata = {1'b0, p1_r};
      REG_P2:       cfg_prdata = {1'b0, p2_r};
      default:      cfg_prdata = '0;
    endcase
  end

  coef_t coef;
  assign coef.k1 = {k1_r[COEF_W-1], k1_r};
  assign coef.k2 = {k2_r[COEF_W-1], k2_r};
  assign coef.p1 = {p1_r[COEF_W-1], p1_r};
  assign coef.p2 = {p2_r[COEF_W-1], p2_r};

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  logic [FOC_W-1:0] fx_eff, fy_eff;
  assign fx_eff = (focal_x_r == '0) ? FOC_W'(1) : focal_x_r;
  assign fy_eff = (focal_y_r == '0) ? FOC_W'(1) : focal_y_r;

  logic [PIX_W:0]   dfx, dfy;
  logic [PIX_W-1:0] magx, magy;
  div_t             divx_nxt, divy_nxt;

  always_comb begin
    dfx  = {1'b0, in_tdata[11:0]} - {1'b0, center_x_r};
    dfy  = {1'b0, in_tdata[23:12]} - {1'b0, center_y_r};
    magx = dfx[PIX_W] ? PIX_W'(-dfx) : dfx[PIX_W-1:0];
    magy = dfy[PIX_W] ? PIX_W'(-dfy) : dfy[PIX_W-1:0];
    divx_nxt.rem = '0;
    divx_nxt.q   = '0;
    divx_nxt.neg = dfx[PIX_W];
    divx_nxt.n   = {magx, FRAC'(0)} + DIV_W'(fx_eff[FOC_W-1:1]);
    divy_nxt.rem = '0;
    divy_nxt.q   = '0;
    divy_nxt.neg = dfy[PIX_W];
    divy_nxt.n   = {magy, FRAC'(0)} + DIV_W'(fy_eff[FOC_W-1:1]);
  end

  div_t       divx_r [0:DIV_W];
  div_t       divy_r [0:DIV_W];
  logic [DIV_W:0] dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (adv) begin
      dv_r <= {dv_r[DIV_W-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      divx_r[0] <= divx_nxt;
      divy_r[0] <= divy_nxt;
    end
  end

  for (genvar s = 1; s <= DIV_W; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        divx_r[s] <= div_step(divx_r[s-1], fx_eff);
        divy_r[s] <= div_step(divy_r[s-1], fy_eff);
      end
    end
  end

  pt_t  chain [0:NPASS];
  logic cv    [0:NPASS];
  logic nv_r;
  pt_t  norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (adv) begin
      nv_r <= dv_r[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      norm_r.x  <= div_final(divx_r[DIV_W]);
      norm_r.y  <= div_final(divy_r[DIV_W]);
      norm_r.xd <= div_final(divx_r[DIV_W]);
      norm_r.yd <= div_final(divy_r[DIV_W]);
    end
  end

  assign chain[0] = norm_r;
  assign cv[0]    = nv_r;

  for (genvar i = 0; i < NPASS; i++) begin : g_pass
    lup_distort_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (cv[i]),
      .in_pt     (chain[i]),
      .coef      (coef),
      .out_valid (cv[i+1]),
      .out_pt    (chain[i+1])
    );
  end

  assign out_tvalid = cv[NPASS];
  assign out_tdata  = {chain[NPASS].y, chain[NPASS].x};

`include "lens_undistort_point_macros.svh"

  `LUP_ASSERT(a_stall_blocks_input, (out_tvalid && !out_tready) |-> !in_tready)
  `LUP_ASSERT(a_stall_holds_result, (out_tvalid && !out_tready) |=> $stable(out_tdata))
  `LUP_ASSERT_RST(a_reset_empties, (!rst_n) |=> !out_tvalid)

endmodule
